/* rtl/core/pts_pkg.sv */
// Shared types and constants for the stream timestamp span tracker.
package pts_pkg;

    localparam int SID_W       = 13;
    localparam int TS_W        = 32;
    localparam int SLOT_W      = 6;
    localparam int SPAN_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_NEW     = 2'd1,
        ST_DROPPED = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MERGE,
        B_SPAN,
        B_OUT
    } t_back_state;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [TS_W-1:0]     ts;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic pair_used;
    } t_front_stat;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        logic [SPAN_W-1:0]   entry_span;
        logic [SPAN_W-1:0]   largest_span;
    } t_result;

endpackage

/* rtl/core/pts_front.sv */
// Front end: takes an item, matches its stream id against the table and classifies it.
module pts_front #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [pts_pkg::SID_W-1:0] i_stream_id,
    input  logic [pts_pkg::TS_W-1:0]  i_time_stamp,
    input  pts_pkg::t_queue_stat      i_q_stat,
    output logic                      o_push,
    output pts_pkg::t_cmd             o_cmd,
    output pts_pkg::t_front_stat      o_stat
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic                      r_valid;
    logic [pts_pkg::SID_W-1:0] r_sid;
    logic [pts_pkg::TS_W-1:0]  r_ts;
    logic [TABLE_ENTRIES-1:0]  r_used;
    logic [pts_pkg::SID_W-1:0] r_stream [TABLE_ENTRIES];

    logic                      hit_found;
    logic [IDX_W-1:0]          hit_idx;
    logic                      claim_new;

    // Every entry is compared at once; scanning downwards leaves the lowest hit.
    always_comb begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (!r_used[k] || (r_stream[k] == r_sid)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(k);
            end
        end
    end

    always_comb begin
        o_cmd.ts   = r_ts;
        o_cmd.slot = '0;
        if (r_ts == '0) begin
            o_cmd.status = pts_pkg::ST_IGNORED;
        end else if (hit_found) begin
            o_cmd.status = r_used[hit_idx] ? pts_pkg::ST_UPDATED : pts_pkg::ST_NEW;
            o_cmd.slot   = pts_pkg::SLOT_W'(hit_idx);
        end else begin
            o_cmd.status = pts_pkg::ST_DROPPED;
        end
    end

    assign o_push    = r_valid && !i_q_stat.full;
    assign claim_new = o_push && (o_cmd.status == pts_pkg::ST_NEW);

    assign o_stat.busy      = r_valid;
    assign o_stat.pair_used = r_used[0] && r_used[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= '0;
        end else begin
            if (i_accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
            if (claim_new) begin
                r_used[hit_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sid <= i_stream_id;
            r_ts  <= i_time_stamp;
        end
        if (claim_new) begin
            r_stream[hit_idx] <= r_sid;
        end
    end

endmodule

/* rtl/core/pts_queue.sv */
// Short queue of classified items between the front and back ends.
module pts_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pts_pkg::t_cmd        i_cmd,
    input  logic                 i_pop,
    output pts_pkg::t_cmd        o_cmd,
    output pts_pkg::t_queue_stat o_stat
);

    localparam int PTR_W = $clog2(pts_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pts_pkg::QUEUE_DEPTH + 1);

    pts_pkg::t_cmd    r_mem [pts_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(pts_pkg::QUEUE_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/core/pts_back.sv */
// Back end: widens the entry's time range, forms its span and keeps the largest span.
module pts_back #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pts_pkg::t_queue_stat i_q_stat,
    input  pts_pkg::t_cmd        i_cmd,
    output logic                 o_pop,
    output logic                 o_busy,
    output logic                 o_valid,
    output pts_pkg::t_result     o_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    pts_pkg::t_back_state       r_state;
    pts_pkg::t_back_state       n_state;
    pts_pkg::t_cmd              r_cmd;
    pts_pkg::t_cmd              n_cmd;
    logic [pts_pkg::TS_W-1:0]   r_lo;
    logic [pts_pkg::TS_W-1:0]   n_lo;
    logic [pts_pkg::TS_W-1:0]   r_hi;
    logic [pts_pkg::TS_W-1:0]   n_hi;
    logic [pts_pkg::SPAN_W-1:0] r_span;
    logic [pts_pkg::SPAN_W-1:0] n_span;
    logic [pts_pkg::SPAN_W-1:0] r_widest;
    logic [pts_pkg::SPAN_W-1:0] n_widest;
    logic                       r_valid;
    logic                       n_valid;
    pts_pkg::t_result           r_result;
    pts_pkg::t_result           n_result;

    // Earliest and latest times per entry, in a single-port store: reads and writes share one address.
    logic [pts_pkg::TS_W-1:0]   r_mem_lo [TABLE_ENTRIES];
    logic [pts_pkg::TS_W-1:0]   r_mem_hi [TABLE_ENTRIES];
    logic [pts_pkg::TS_W-1:0]   r_rd_lo;
    logic [pts_pkg::TS_W-1:0]   r_rd_hi;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_addr;
    logic [pts_pkg::TS_W-1:0]   mem_wlo;
    logic [pts_pkg::TS_W-1:0]   mem_whi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pts_pkg::B_IDLE;
            r_widest <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_widest <= n_widest;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_span   <= n_span;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_lo[mem_addr] <= mem_wlo;
            r_mem_hi[mem_addr] <= mem_whi;
        end
        r_rd_lo <= r_mem_lo[mem_addr];
        r_rd_hi <= r_mem_hi[mem_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_span   = r_span;
        n_widest = r_widest;
        n_valid  = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_addr = r_cmd.slot[IDX_W-1:0];
        mem_wlo  = r_cmd.ts;
        mem_whi  = r_cmd.ts;

        case (r_state)
            pts_pkg::B_IDLE: begin
                // The read address follows the queue head so that the stored
                // range is ready in the merge step.
                mem_addr = i_cmd.slot[IDX_W-1:0];
                mem_wlo  = i_cmd.ts;
                mem_whi  = i_cmd.ts;
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.status)
                        pts_pkg::ST_NEW: begin
                            mem_we  = 1'b1;
                            n_lo    = i_cmd.ts;
                            n_hi    = i_cmd.ts;
                            n_state = pts_pkg::B_SPAN;
                        end
                        pts_pkg::ST_UPDATED: begin
                            n_state = pts_pkg::B_MERGE;
                        end
                        default: begin
                            n_lo    = '0;
                            n_hi    = '0;
                            n_state = pts_pkg::B_SPAN;
                        end
                    endcase
                end
            end
            pts_pkg::B_MERGE: begin
                n_lo    = (r_cmd.ts < r_rd_lo) ? r_cmd.ts : r_rd_lo;
                n_hi    = (r_cmd.ts > r_rd_hi) ? r_cmd.ts : r_rd_hi;
                mem_we  = 1'b1;
                mem_wlo = n_lo;
                mem_whi = n_hi;
                n_state = pts_pkg::B_SPAN;
            end
            pts_pkg::B_SPAN: begin
                n_span  = r_hi - r_lo;
                n_state = pts_pkg::B_OUT;
            end
            pts_pkg::B_OUT: begin
                if (r_span > r_widest) begin
                    n_widest = r_span;
                end
                n_valid               = 1'b1;
                n_result.status       = r_cmd.status;
                n_result.slot         = r_cmd.slot;
                n_result.entry_span   = r_span;
                n_result.largest_span = n_widest;
                n_state               = pts_pkg::B_IDLE;
            end
            default: begin
                n_state = pts_pkg::B_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != pts_pkg::B_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/core/pid_timestamp_span_tracker_top.sv */
// Top level of the stream timestamp span tracker.
// Each item (stream id, 90 kHz timestamp) is taken when start is high and busy is low, and
// exactly one result follows, shown for a single cycle with o_result_valid; the receiver
// cannot hold it off. The item passes through the front end's register and the queue to the
// back end. Busy stays high until the result is shown and falls in the cycle that shows it,
// so a new item can be taken in that same cycle. For an item that updates an existing entry,
// the back end reads the entry's stored time range from its single-port store and merges the
// new timestamp; for every item it then forms the span and updates the running maximum, one
// step a cycle. No clearing pass is needed after reset: only the used flags are cleared.
module pid_timestamp_span_tracker_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pts_pkg::SID_W-1:0]    i_stream_id,
    input  logic [pts_pkg::TS_W-1:0]     i_time_stamp,
    output logic                         o_result_valid,
    output logic [1:0]                   o_status,
    output logic [pts_pkg::SLOT_W-1:0]   o_slot,
    output logic [pts_pkg::SPAN_W-1:0]   o_entry_span,
    output logic [pts_pkg::SPAN_W-1:0]   o_largest_span,
    output logic                         o_two_streams_seen
);

    logic                 accept;
    logic                 push;
    logic                 pop;
    logic                 back_busy;
    pts_pkg::t_cmd        front_cmd;
    pts_pkg::t_cmd        head_cmd;
    pts_pkg::t_front_stat front_stat;
    pts_pkg::t_queue_stat q_stat;
    pts_pkg::t_result     result;

    assign busy   = front_stat.busy || !q_stat.empty || back_busy;
    assign accept = start && !busy;

    pts_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_stream_id  (i_stream_id),
        .i_time_stamp (i_time_stamp),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_cmd        (front_cmd),
        .o_stat       (front_stat)
    );

    pts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    pts_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (head_cmd),
        .o_pop    (pop),
        .o_busy   (back_busy),
        .o_valid  (o_result_valid),
        .o_result (result)
    );

    assign o_status           = result.status;
    assign o_slot             = result.slot;
    assign o_entry_span       = result.entry_span;
    assign o_largest_span     = result.largest_span;
    assign o_two_streams_seen = front_stat.pair_used;

    // A result only ever follows a cycle in which an item was in flight.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without an item in flight");

    // A freshly taken item cannot produce its result in the very next cycle.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_valid)
        else $error("result strobe directly after an item was taken");

    // A newly claimed entry has no span yet.
    a_new_entry_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == pts_pkg::ST_NEW)) |-> (o_entry_span == '0))
        else $error("new entry reported with a non-zero span");

    // The running maximum never falls below the span just reported.
    a_largest_covers_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_largest_span >= o_entry_span))
        else $error("largest span below the entry span");

endmodule
